>>> rtl/core/apdu_command_length_parser_defines.svh
// Assertion macros used by the checker of this block.
`ifndef APDU_COMMAND_LENGTH_PARSER_DEFINES_SVH
`define APDU_COMMAND_LENGTH_PARSER_DEFINES_SVH

// Check a property outside reset.
`define ACLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ACLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/aclp_pkg.sv
package aclp_pkg;

  localparam int unsigned HDR_DEPTH = 7;
  localparam logic [7:0]  INS_GET_RESPONSE = 8'hC0;
  localparam logic [16:0] NE_SHORT_MAX = 17'd256;
  localparam logic [16:0] NE_EXT_MAX   = 17'd65536;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [2:0]  OFF_NONE     = 3'd0;
  localparam logic [2:0]  OFF_SHORT    = 3'd5;
  localparam logic [2:0]  OFF_EXT      = 3'd7;

  // One finished command, as handed from the front to the back.
  typedef struct packed {
    logic [15:0]                 size;
    logic                        sat;
    logic [HDR_DEPTH-1:0][7:0]   hdr;
    logic [7:0]                  prev;
    logic [7:0]                  cur;
  } cmd_rec_t;

  // One decoded result.
  typedef struct packed {
    logic        count_saturated;
    logic        too_short;
    logic        is_get_response;
    logic        is_extended;
    logic [2:0]  data_offset;
    logic [16:0] expected_length;
    logic [15:0] data_length;
    logic [7:0]  param_two;
    logic [7:0]  param_one;
    logic [7:0]  instruction;
    logic [7:0]  class_byte;
  } result_t;

endpackage

>>> rtl/core/apdu_command_length_parser.sv
// Command APDU length parser. Feed one command byte per beat on the slave side,
// with s_tlast high on the final byte; one result beat leaves on the master side
// per command, carrying the header bytes, Nc, Ne (256 for a four-byte command or
// a short Le of zero, 65536 for an extended Le of zero, else 0 when no Le was
// given) and the data offset, plus flags for the extended form, GET RESPONSE, a
// command of fewer than four bytes and a byte count that saturated above 65535.
// The block takes one byte every cycle while the queue has room; the front byte
// counter updates on every byte taken. A result passes through the command queue
// and then the output register, waiting while the master side stalls. The queue
// holds QUEUE_DEPTH finished commands, so bytes keep flowing while results wait.
module apdu_command_length_parser
  import aclp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] class_byte, [15:8] instruction,
                                 // [23:16] param_one, [31:24] param_two,
                                 // [47:32] data_length, [64:48] expected_length,
                                 // [67:65] data_offset, [71:68] zero
  output logic [3:0]  m_tuser    // [0] is_extended, [1] is_get_response,
                                 // [2] too_short, [3] count_saturated
);

  cmd_rec_t push_rec;
  cmd_rec_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  // Front: count bytes, hold the header and hand over each finished command.
  aclp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .full     (full),
    .push     (push),
    .rec      (push_rec)
  );

  // Queue: decouple byte intake from result delivery.
  aclp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Back: decode the lengths and hold the result until taken.
  aclp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/core/aclp_front.sv
module aclp_front
  import aclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       full,
  output logic       push,
  output cmd_rec_t   rec
);

  logic [15:0]               byte_count, byte_count_next;
  logic [HDR_DEPTH-1:0][7:0] header_bytes, header_bytes_next;
  logic [7:0]                previous_byte;
  logic                      overflow_seen, overflow_seen_next;
  logic                      beat;

  assign s_tready = !full;
  assign beat     = s_tvalid && s_tready;
  assign push     = beat && s_tlast;

  always_comb begin
    header_bytes_next = header_bytes;
    if (byte_count < 16'(HDR_DEPTH)) begin
      header_bytes_next[byte_count[2:0]] = s_tdata;
    end
    if (byte_count == COUNT_MAX) begin
      byte_count_next    = byte_count;
      overflow_seen_next = 1'b1;
    end else begin
      byte_count_next    = byte_count + 16'd1;
      overflow_seen_next = overflow_seen;
    end
    rec.size = byte_count_next;
    rec.sat  = overflow_seen_next;
    rec.hdr  = header_bytes_next;
    rec.prev = previous_byte;
    rec.cur  = s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      header_bytes  <= '0;
      previous_byte <= '0;
      overflow_seen <= 1'b0;
    end else if (beat) begin
      if (s_tlast) begin
        // command ends: clear for the next one
        byte_count    <= '0;
        header_bytes  <= '0;
        previous_byte <= '0;
        overflow_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        header_bytes  <= header_bytes_next;
        previous_byte <= s_tdata;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

>>> rtl/core/aclp_queue.sv
module aclp_queue
  import aclp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cmd_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output cmd_rec_t head,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_rec_t               mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/aclp_back.sv
module aclp_back
  import aclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  cmd_rec_t    head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // class_byte, instruction, param_one, param_two,
                                 // data_length, expected_length, data_offset, 4 zero bits
  output logic [3:0]  m_tuser    // is_extended, is_get_response, too_short, count_saturated
);

  result_t     res, res_next;
  logic [16:0] size_ext;
  logic [16:0] w;
  logic [16:0] tail_le;

  assign pop = !empty && (!m_tvalid || m_tready);

  always_comb begin
    res_next = '0;
    size_ext = {1'b0, head.size};
    w        = {1'b0, head.hdr[5], head.hdr[6]};
    tail_le  = {1'b0, head.prev, head.cur};
    if (!head.sat && head.size < 16'd4) begin
      res_next.too_short = 1'b1;
    end else begin
      if (!head.sat && head.size == 16'd4) begin
        res_next.expected_length = NE_SHORT_MAX;
      end else if (!head.sat && head.size == 16'd5) begin
        res_next.expected_length = (head.hdr[4] == 8'd0) ? NE_SHORT_MAX :
                                   {9'd0, head.hdr[4]};
      end else if (head.hdr[4] == 8'd0 && (head.sat || head.size >= 16'd7)) begin
        res_next.is_extended = 1'b1;
        if (!head.sat && head.size == 16'd7) begin
          res_next.expected_length = (w == '0) ? NE_EXT_MAX : w;
        end else begin
          res_next.data_length = w[15:0];
          res_next.data_offset = OFF_EXT;
          if (!head.sat && (w + 17'd9) == size_ext) begin
            res_next.expected_length = (tail_le == '0) ? NE_EXT_MAX : tail_le;
          end
        end
      end else begin
        res_next.data_length = {8'd0, head.hdr[4]};
        res_next.data_offset = OFF_SHORT;
        if (!head.sat && ({9'd0, head.hdr[4]} + 17'd6) == size_ext) begin
          res_next.expected_length = (head.cur == 8'd0) ? NE_SHORT_MAX :
                                     {9'd0, head.cur};
        end
      end
      res_next.class_byte      = head.hdr[0];
      res_next.instruction     = head.hdr[1];
      res_next.param_one       = head.hdr[2];
      res_next.param_two       = head.hdr[3];
      res_next.is_get_response = (head.hdr[1] == INS_GET_RESPONSE);
      res_next.count_saturated = head.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  assign m_tdata = {4'd0, res.data_offset, res.expected_length, res.data_length,
                    res.param_two, res.param_one, res.instruction, res.class_byte};
  assign m_tuser = {res.count_saturated, res.too_short, res.is_get_response,
                    res.is_extended};

endmodule

>>> rtl/core/aclp_checker.sv
`include "apdu_command_length_parser_defines.svh"

module aclp_checker
  import aclp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [3:0]  m_tuser
);

  `ACLP_ASSERT(a_hold_stall,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
    "result changed while stalled")
  `ACLP_ASSERT(a_short_zero,
    m_tvalid && m_tuser[2] |-> m_tdata == 72'd0 && m_tuser[1:0] == 2'd0 && !m_tuser[3],
    "too-short result carries data")
  `ACLP_ASSERT(a_ext_offset,
    m_tvalid && m_tuser[0] |-> m_tdata[67:65] == OFF_EXT || m_tdata[67:65] == OFF_NONE,
    "extended form with short offset")
  `ACLP_ASSERT(a_short_offset,
    m_tvalid && m_tdata[67:65] == OFF_SHORT |-> !m_tuser[0],
    "short offset flagged extended")
  `ACLP_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind apdu_command_length_parser aclp_checker u_aclp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> sim/apdu_sb_pkg.sv
package apdu_sb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import aclp_pkg::*;

  localparam int MAX_REPORTS = 40;

  class apdu_scoreboard;
    logic [15:0] byte_cnt;
    logic [7:0]  hdr [HDR_DEPTH];
    logic [7:0]  prev_byte;
    bit          saturated;
    result_t     decoded_q[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned commands;
    int unsigned n_short;
    int unsigned n_ext;
    int unsigned n_sat;
    int unsigned n_gr;
    int unsigned n_ne;

    function new();
      clear_command();
    endfunction

    function void clear_command();
      byte_cnt = '0;
      foreach (hdr[i]) hdr[i] = '0;
      prev_byte = '0;
      saturated = 1'b0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Decode the command held so far; cur is its final byte, prior the one ahead of it.
    function result_t decode_command(logic [7:0] cur, logic [7:0] prior);
      result_t     r;
      int          size;
      logic [15:0] w;
      logic [15:0] le;
      r    = '0;
      size = int'(byte_cnt);
      w    = {hdr[5], hdr[6]};
      le   = {prior, cur};
      if (!saturated && size < 4) begin
        r.too_short = 1'b1;
        return r;
      end
      if (!saturated && size == 4) begin
        r.expected_length = NE_SHORT_MAX;
      end else if (!saturated && size == 5) begin
        r.expected_length = (hdr[4] == 8'h00) ? NE_SHORT_MAX : {9'd0, hdr[4]};
      end else if (hdr[4] == 8'h00 && (saturated || size >= 7)) begin
        r.is_extended = 1'b1;
        if (!saturated && size == 7) begin
          r.expected_length = (w == 16'h0000) ? NE_EXT_MAX : {1'b0, w};
        end else begin
          r.data_length = w;
          r.data_offset = OFF_EXT;
          if (!saturated && int'(w) + 9 == size)
            r.expected_length = (le == 16'h0000) ? NE_EXT_MAX : {1'b0, le};
        end
      end else begin
        r.data_length = {8'd0, hdr[4]};
        r.data_offset = OFF_SHORT;
        if (!saturated && int'(hdr[4]) + 6 == size)
          r.expected_length = (cur == 8'h00) ? NE_SHORT_MAX : {9'd0, cur};
      end
      r.class_byte      = hdr[0];
      r.instruction     = hdr[1];
      r.param_one       = hdr[2];
      r.param_two       = hdr[3];
      r.is_get_response = (hdr[1] == INS_GET_RESPONSE);
      r.count_saturated = saturated;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic is_final);
      logic [7:0] prior;
      result_t    r;
      prior = prev_byte;
      bytes_seen++;
      if (byte_cnt < HDR_DEPTH) hdr[byte_cnt] = b;
      if (byte_cnt == COUNT_MAX) saturated = 1'b1;
      else byte_cnt++;
      prev_byte = b;
      if (is_final) begin
        r = decode_command(b, prior);
        decoded_q.push_back(r);
        commands++;
        n_short += r.too_short;
        n_ext   += r.is_extended;
        n_sat   += r.count_saturated;
        n_gr    += r.is_get_response;
        n_ne    += (r.expected_length != '0);
        clear_command();
      end
    endfunction

    function void compare_field(string what, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
      end
    endfunction

    function void check_decode(logic [71:0] data, logic [3:0] user);
      result_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat, expected none, actual tdata 0x%h tuser 0x%h",
                   $time, data, user);
        return;
      end
      want = decoded_q.pop_front();
      compare_field("class_byte",      want.class_byte,      data[7:0]);
      compare_field("instruction",     want.instruction,     data[15:8]);
      compare_field("param_one",       want.param_one,       data[23:16]);
      compare_field("param_two",       want.param_two,       data[31:24]);
      compare_field("data_length",     want.data_length,     data[47:32]);
      compare_field("expected_length", want.expected_length, data[64:48]);
      compare_field("data_offset",     want.data_offset,     data[67:65]);
      compare_field("tdata padding",   '0,                   data[71:68]);
      compare_field("is_extended",     want.is_extended,     user[0]);
      compare_field("is_get_response", want.is_get_response, user[1]);
      compare_field("too_short",       want.too_short,       user[2]);
      compare_field("count_saturated", want.count_saturated, user[3]);
    endfunction
  endclass

endpackage

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aclp_pkg::*;
  import apdu_sb_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int WATCHDOG_LIMIT  = 5000;  // cycles without any beat on either side
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 8;     // result trails its final byte through the queue and output register
  localparam int RANDOM_BYTES    = 1120;
  localparam int QUIET_FROM      = 900;   // random bytes after which idling stops

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;    // [7:0] data_byte
  logic        s_tlast  = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // [7:0] class_byte .. [67:65] data_offset, [71:68] zero
  logic [3:0]  m_tuser;          // [0] is_extended, [1] is_get_response,
                                 // [2] too_short, [3] count_saturated

  bit          tx_gaps;
  bit          rx_stalls;
  bit          hold_off_req;
  bit          hold_off_done;
  int          random_bytes;
  int          quiet_cycles;
  logic [7:0]  frame_q[$];       // command being assembled for the sender

  apdu_scoreboard sb = new();

  apdu_command_length_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: mostly ready, random stall bursts while enabled, and one long
  // hold-off on request so the command queue fills and the byte side backs up.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req  = 1'b0;
        hold_off_done = 1'b1;
      end else if (rx_stalls && $urandom_range(0, 99) < 12) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Monitor both sides at the edge. Outputs are checked before the input beat
  // is noted; a result never leaves in the cycle its final byte is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_decode(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one byte, with an optional idle burst ahead of it; hold until taken.
  task automatic send_byte(input logic [7:0] b, input logic is_final);
    if (tx_gaps && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_final;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic push_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic push_word(input logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endtask

  // Le values lean towards zero, which stands for the largest length.
  function automatic logic [15:0] pick_le16();
    return ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom);
  endfunction

  // Start a command with a random header; INS is GET RESPONSE a quarter of the time.
  task automatic begin_frame();
    frame_q.delete();
    frame_q.push_back(8'($urandom));
    frame_q.push_back(($urandom_range(0, 3) == 0) ? INS_GET_RESPONSE : 8'($urandom));
    push_random(2);
  endtask

  // Mostly well-formed commands with random content, some of them broken by a
  // byte either way, and a quarter plain noise of 1 to 12 bytes.
  task automatic build_random_command();
    int          pick;
    int          nc;
    logic [15:0] le;
    pick = $urandom_range(0, 99);
    le   = pick_le16();
    if (pick >= 75) begin
      frame_q.delete();
      push_random($urandom_range(1, 12));
      return;
    end
    begin_frame();
    if (pick < 10) begin
      // header alone
    end else if (pick < 20) begin
      frame_q.push_back(le[7:0]);
    end else if (pick < 45) begin
      nc = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
      frame_q.push_back(8'(nc));
      push_random(nc);
      if ($urandom_range(0, 1)) frame_q.push_back(le[7:0]);
    end else begin
      nc = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 600) : $urandom_range(0, 16);
      frame_q.push_back(8'h00);
      if (nc == 0) begin
        push_word(le);
      end else begin
        push_word(16'(nc));
        push_random(nc);
        if ($urandom_range(0, 1)) push_word(le);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) void'(frame_q.pop_back());
      else frame_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    int cmd_idx;
    repeat (2) @(posedge clk);
    rst      <= 1'b0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;

    // Too short: one, two and three bytes, GET RESPONSE ignored in the last.
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hFF, 8'hFF};
    send_frame();
    frame_q = '{8'h00, INS_GET_RESPONSE, 8'h00};
    send_frame();
    // Four bytes: Ne of 256, header extremes.
    frame_q = '{8'h80, INS_GET_RESPONSE, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // Five bytes: Le of zero means 256, then the top Le.
    frame_q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'hFF};
    send_frame();
    // Short form: data without Le, data with Le zero and Le 0xFF.
    frame_q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h01, 8'h5A};
    send_frame();
    frame_q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h03, 8'hAA, 8'hBB, 8'hCC, 8'h00};
    send_frame();
    frame_q = '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF};
    send_frame();
    // Short form with Nc zero: offset stays at five, trailing byte is Le.
    frame_q = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h37};
    send_frame();
    frame_q = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    // Extended form of seven bytes: Le zero means 65536, then the top Le.
    frame_q = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_frame();
    // Extended form with data: no Le, Le zero, Le 0x1234.
    frame_q = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h11, 8'h22};
    send_frame();
    frame_q = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h11, 8'h22,
                8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h11, 8'h22,
                8'h12, 8'h34};
    send_frame();
    // Inconsistent lengths: Nc reported as decoded, no Le recognised.
    frame_q = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hEE};
    send_frame();
    frame_q = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h03};
    send_frame();
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame();

    // Random commands; idling switches off and on in stretches, stops for the
    // tail, and the receiver holds off once while commands keep coming.
    cmd_idx = 0;
    while (random_bytes < RANDOM_BYTES) begin
      tx_gaps   = (random_bytes < QUIET_FROM) && (cmd_idx % 24 < 16);
      rx_stalls = (random_bytes < QUIET_FROM) && (cmd_idx % 20 < 13);
      if (cmd_idx == 30) hold_off_req = 1'b1;
      build_random_command();
      random_bytes += frame_q.size();
      send_frame();
      cmd_idx++;
    end
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    s_tvalid <= 1'b0;

    // Drain, then allow for the result path through the queue and output register.
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands over %0d bytes: %0d too short, %0d extended,",
             sb.commands, sb.bytes_seen, sb.n_short, sb.n_ext);
    $display("%0d saturated, %0d GET RESPONSE, %0d with Ne; long receiver hold-off %s",
             sb.n_sat, sb.n_gr, sb.n_ne, hold_off_done ? "done" : "missed");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/aclp_pkg.sv
rtl/core/aclp_front.sv
rtl/core/aclp_queue.sv
rtl/core/aclp_back.sv
rtl/core/apdu_command_length_parser.sv
rtl/core/aclp_checker.sv
sim/apdu_sb_pkg.sv
sim/tb_top.sv
